// ===== rtl/fbm_pkg.sv =====
// Shared constants and types for the byte mailbox FIFO.
`default_nettype none
package fbm_pkg;

    localparam int FIFO_DEPTH = 266;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int DATA_W     = 8;
    localparam int FILL_W     = 9;
    localparam int FAULT_W    = 2;

    localparam logic [DATA_W-1:0] STATUS_P0 = 8'hF0;
    localparam logic [DATA_W-1:0] STATUS_P1 = 8'hF1;
    localparam logic [DATA_W-1:0] STATUS_EMPTY = 8'h00;

    localparam logic [DATA_W-1:0] CTRL_CLEAR_A = 8'h00;
    localparam logic [DATA_W-1:0] CTRL_CLEAR_B = 8'h01;
    localparam logic [DATA_W-1:0] CTRL_CLEAR_C = 8'h03;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;
    localparam logic REG_DATA   = 1'b0;
    localparam logic REG_CTRL   = 1'b1;

    localparam logic [FAULT_W-1:0] FAULT_NONE       = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_POP_EMPTY  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_PUSH_FULL  = 2'd2;

    typedef struct packed {
        logic              shift;
        logic              push;
        logic [DATA_W-1:0] wdata;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== rtl/fbm_cell.sv =====
// One byte cell of the FIFO chain: shifts down from its neighbor or loads a pushed byte.
`default_nettype none
module fbm_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  fbm_pkg::t_cell_ctrl    i_ctrl,
    input  wire                          i_sel,
    input  wire  [fbm_pkg::DATA_W-1:0]   i_next,
    output logic [fbm_pkg::DATA_W-1:0]   o_data
);

    logic [fbm_pkg::DATA_W-1:0] r_data;
    logic [fbm_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift) begin
            n_data = i_next;
        end else if (i_ctrl.push && i_sel) begin
            n_data = i_ctrl.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

// ===== rtl/fbm_chain.sv =====
// Row of byte cells; the head cell is read out and every pop moves the row down one place.
`default_nettype none
module fbm_chain (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  fbm_pkg::t_cell_ctrl    i_ctrl,
    input  wire  [fbm_pkg::CNT_W-1:0]    i_count,
    output logic [fbm_pkg::DATA_W-1:0]   o_head
);

    logic [fbm_pkg::DATA_W-1:0] w_data [fbm_pkg::FIFO_DEPTH];

    for (genvar g = 0; g < fbm_pkg::FIFO_DEPTH; g++) begin : g_cell
        logic [fbm_pkg::DATA_W-1:0] w_next;
        logic                       w_sel;

        if (g == fbm_pkg::FIFO_DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end

        assign w_sel = (i_count == fbm_pkg::CNT_W'(g));

        fbm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (i_ctrl),
            .i_sel   (w_sel),
            .i_next  (w_next),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule
`default_nettype wire

// ===== rtl/byte_fifo_mailbox_device_top.sv =====
// Top level of the byte mailbox FIFO: bus access decode, fill count and result register.
// The block takes one bus access per cycle while its single output register is free or
// being read, and presents the result from that register in the next cycle; a new access
// is taken in the same cycle that the previous result is taken. The FIFO is a row of byte
// cells that all move down one place on a data read, so a pop and a push each take effect
// when accepted. The status setting is written on its own channel, which is always ready.
`default_nettype none
module byte_fifo_mailbox_device_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire                            i_cfg_protocol_select,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire                            i_mode,
    input  wire                            i_reg_sel,
    input  wire  [fbm_pkg::DATA_W-1:0]     i_wdata,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [fbm_pkg::DATA_W-1:0]     o_rdata,
    output logic [fbm_pkg::FILL_W-1:0]     o_fill_level,
    output logic [fbm_pkg::FAULT_W-1:0]    o_fault
);

    logic                           r_protocol_select;
    logic [fbm_pkg::CNT_W-1:0]      r_count;
    logic [fbm_pkg::CNT_W-1:0]      n_count;
    logic                           r_out_valid;
    logic [fbm_pkg::DATA_W-1:0]     r_rdata;
    logic [fbm_pkg::DATA_W-1:0]     n_rdata;
    logic [fbm_pkg::FAULT_W-1:0]    r_fault;
    logic [fbm_pkg::FAULT_W-1:0]    n_fault;
    logic                           w_accept;
    logic [fbm_pkg::DATA_W-1:0]     w_head;
    fbm_pkg::t_cell_ctrl            w_ctrl;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign w_accept    = i_valid && o_ready;

    always_comb begin
        n_count      = r_count;
        n_rdata      = '0;
        n_fault      = fbm_pkg::FAULT_NONE;
        w_ctrl.shift = 1'b0;
        w_ctrl.push  = 1'b0;
        w_ctrl.wdata = i_wdata;
        if (i_mode == fbm_pkg::MODE_READ) begin
            if (i_reg_sel == fbm_pkg::REG_CTRL) begin
                if (r_count != '0) begin
                    n_rdata = r_protocol_select ? fbm_pkg::STATUS_P1 : fbm_pkg::STATUS_P0;
                end else begin
                    n_rdata = fbm_pkg::STATUS_EMPTY;
                end
            end else begin
                n_rdata      = w_head;
                w_ctrl.shift = w_accept;
                if (r_count != '0) begin
                    n_count = r_count - fbm_pkg::CNT_W'(1);
                end else begin
                    n_fault = fbm_pkg::FAULT_POP_EMPTY;
                end
            end
        end else begin
            if (i_reg_sel == fbm_pkg::REG_CTRL) begin
                if (i_wdata inside {fbm_pkg::CTRL_CLEAR_A, fbm_pkg::CTRL_CLEAR_B,
                                    fbm_pkg::CTRL_CLEAR_C}) begin
                    n_count = '0;
                end
            end else begin
                if (r_count < fbm_pkg::CNT_W'(fbm_pkg::FIFO_DEPTH)) begin
                    w_ctrl.push = w_accept;
                    n_count     = r_count + fbm_pkg::CNT_W'(1);
                end else begin
                    n_fault = fbm_pkg::FAULT_PUSH_FULL;
                end
            end
        end
    end

    fbm_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_count (r_count),
        .o_head  (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol_select <= 1'b0;
            r_count           <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_protocol_select <= i_cfg_protocol_select;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata <= n_rdata;
            r_fault <= n_fault;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_rdata      = r_rdata;
    assign o_fill_level = fbm_pkg::FILL_W'(r_count);
    assign o_fault      = r_fault;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fbm_pkg::CNT_W'(fbm_pkg::FIFO_DEPTH))
        else $error("fill count exceeds the FIFO depth");

    a_pop_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fault == fbm_pkg::FAULT_POP_EMPTY) |-> (r_count == '0))
        else $error("pop from empty reported with a nonzero fill count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fault == fbm_pkg::FAULT_PUSH_FULL)
            |-> (r_count == fbm_pkg::CNT_W'(fbm_pkg::FIFO_DEPTH)))
        else $error("dropped push reported while the FIFO is not full");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctrl.push) |=> (r_count == $past(r_count) + fbm_pkg::CNT_W'(1)))
        else $error("accepted push did not grow the fill count by one");
`endif

endmodule
`default_nettype wire

// ===== tb/fbm_reply_checker.sv =====
// Checker for the byte mailbox FIFO: tracks its own copy of the cells and compares every reply.
module fbm_reply_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    input  wire                            i_cfg_ready,
    input  wire                            i_cfg_protocol_select,
    input  wire                            i_in_valid,
    input  wire                            i_in_ready,
    input  wire                            i_mode,
    input  wire                            i_reg_sel,
    input  wire  [fbm_pkg::DATA_W-1:0]     i_wdata,
    input  wire                            i_out_valid,
    input  wire                            i_out_ready,
    input  wire  [fbm_pkg::DATA_W-1:0]     i_rdata,
    input  wire  [fbm_pkg::FILL_W-1:0]     i_fill_level,
    input  wire  [fbm_pkg::FAULT_W-1:0]    i_fault,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_words_in,
    output int                             o_words_out,
    output int                             o_drops,
    output int                             o_empty_pops
);
    import fbm_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  rdata;
        logic [FILL_W-1:0]  fill_level;
        logic [FAULT_W-1:0] fault;
    } mbox_reply_t;

    logic [DATA_W-1:0] cells [FIFO_DEPTH];
    int                held;
    logic              proto_sel;
    mbox_reply_t       owed_replies [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_words_in   = 0;
        o_words_out  = 0;
        o_drops      = 0;
        o_empty_pops = 0;
    end

    function automatic mbox_reply_t mailbox_access(input logic mode, input logic reg_sel,
                                                   input logic [DATA_W-1:0] wdata);
        mbox_reply_t r;
        r.rdata = STATUS_EMPTY;
        r.fault = FAULT_NONE;
        if (mode == MODE_READ) begin
            if (reg_sel == REG_CTRL) begin
                if (held != 0) begin
                    r.rdata = proto_sel ? STATUS_P1 : STATUS_P0;
                end
            end else begin
                r.rdata = cells[0];
                for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
                    cells[i] = cells[i+1];
                end
                if (held != 0) begin
                    held--;
                end else begin
                    r.fault = FAULT_POP_EMPTY;
                end
            end
        end else begin
            if (reg_sel == REG_CTRL) begin
                if (wdata == CTRL_CLEAR_A || wdata == CTRL_CLEAR_B ||
                    wdata == CTRL_CLEAR_C) begin
                    held = 0;
                end
            end else if (held < FIFO_DEPTH) begin
                cells[held] = wdata;
                held++;
            end else begin
                r.fault = FAULT_PUSH_FULL;
            end
        end
        r.fill_level = FILL_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        mbox_reply_t want;
        if (!i_rst_n) begin
            foreach (cells[k]) begin
                cells[k] = '0;
            end
            held      = 0;
            proto_sel = 1'b0;
            owed_replies.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_words_out++;
                if (owed_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, actual %0h/%0d/%0d",
                             $time, i_rdata, i_fill_level, i_fault);
                    o_fail_count++;
                end else begin
                    want = owed_replies.pop_front();
                    if (i_rdata !== want.rdata) begin
                        $display("%0t: rdata mismatch, expected 0x%02h, actual 0x%02h",
                                 $time, want.rdata, i_rdata);
                        o_fail_count++;
                    end
                    if (i_fill_level !== want.fill_level) begin
                        $display("%0t: fill_level mismatch, expected %0d, actual %0d",
                                 $time, want.fill_level, i_fill_level);
                        o_fail_count++;
                    end
                    if (i_fault !== want.fault) begin
                        $display("%0t: fault mismatch, expected %0d, actual %0d",
                                 $time, want.fault, i_fault);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                proto_sel = i_cfg_protocol_select;
            end
            if (i_in_valid && i_in_ready) begin
                want = mailbox_access(i_mode, i_reg_sel, i_wdata);
                if (want.fault == FAULT_PUSH_FULL) begin
                    o_drops++;
                end
                if (want.fault == FAULT_POP_EMPTY) begin
                    o_empty_pops++;
                end
                owed_replies.push_back(want);
                o_words_in++;
            end
        end
        o_pending = owed_replies.size();
    end

endmodule

// ===== tb/tb_byte_fifo_mailbox_device_top.sv =====
// Testbench top for the byte mailbox FIFO: clock, reset, stimulus, pacing and verdict.
module tb_byte_fifo_mailbox_device_top;
    import fbm_pkg::*;

    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 3000;
    localparam int RANDOM_PER_PHASE = 300;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                i_cfg_protocol_select;
    logic                i_valid;
    logic                i_mode;
    logic                i_reg_sel;
    logic [DATA_W-1:0]   i_wdata;
    logic                i_ready;
    logic                o_cfg_ready;
    logic                o_ready;
    logic                o_valid;
    logic [DATA_W-1:0]   o_rdata;
    logic [FILL_W-1:0]   o_fill_level;
    logic [FAULT_W-1:0]  o_fault;

    int snd_idle;
    int rcv_idle;
    int hold_asked  = 0;
    int hold_served = 0;
    int words_sent  = 0;
    int stall_cycles = 0;
    int fail_count;
    int pending;
    int words_in;
    int words_out;
    int drops;
    int empty_pops;

    byte_fifo_mailbox_device_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_protocol_select (i_cfg_protocol_select),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_mode                (i_mode),
        .i_reg_sel             (i_reg_sel),
        .i_wdata               (i_wdata),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_rdata               (o_rdata),
        .o_fill_level          (o_fill_level),
        .o_fault               (o_fault)
    );

    fbm_reply_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_ready           (o_cfg_ready),
        .i_cfg_protocol_select (i_cfg_protocol_select),
        .i_in_valid            (i_valid),
        .i_in_ready            (o_ready),
        .i_mode                (i_mode),
        .i_reg_sel             (i_reg_sel),
        .i_wdata               (i_wdata),
        .i_out_valid           (o_valid),
        .i_out_ready           (i_ready),
        .i_rdata               (o_rdata),
        .i_fill_level          (o_fill_level),
        .i_fault               (o_fault),
        .o_fail_count          (fail_count),
        .o_pending             (pending),
        .o_words_in            (words_in),
        .o_words_out           (words_out),
        .o_drops               (drops),
        .o_empty_pops          (empty_pops)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver honors a hold-off request by keeping ready low for a long stretch.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_asked) begin
                hold_served++;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no word moved for %0d cycles, %0d replies outstanding",
                 $time, stall_cycles, pending);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_word(input logic mode, input logic reg_sel,
                             input logic [DATA_W-1:0] wdata);
        while ($urandom_range(0, 99) < snd_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_reg_sel <= reg_sel;
        i_wdata   <= wdata;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic write_protocol(input logic sel);
        i_cfg_valid           <= 1'b1;
        i_cfg_protocol_select <= sel;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic fill_and_drain();
        send_word(MODE_WRITE, REG_CTRL, CTRL_CLEAR_A);
        repeat (FIFO_DEPTH + 3) send_word(MODE_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
        send_word(MODE_READ, REG_CTRL, 8'($urandom()));
        repeat (FIFO_DEPTH + 4) send_word(MODE_READ, REG_DATA, 8'($urandom()));
    endtask

    task automatic run_random(input int n);
        int                stop_at;
        int                kind;
        int                len;
        logic [DATA_W-1:0] code;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(1, 12);
            if (kind < 35) begin
                repeat (len) send_word(MODE_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
            end else if (kind < 62) begin
                repeat (len) send_word(MODE_READ, REG_DATA, 8'($urandom()));
            end else if (kind < 72) begin
                send_word(MODE_READ, REG_CTRL, 8'($urandom()));
            end else if (kind < 82) begin
                case ($urandom_range(0, 3))
                    0: code = CTRL_CLEAR_A;
                    1: code = CTRL_CLEAR_B;
                    2: code = CTRL_CLEAR_C;
                    default: code = 8'($urandom());
                endcase
                send_word(MODE_WRITE, REG_CTRL, code);
            end else begin
                repeat (len / 3 + 1) send_word(1'($urandom()), 1'($urandom()), 8'($urandom()));
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_valid           = 1'b0;
        i_cfg_protocol_select = 1'b0;
        i_valid               = 1'b0;
        i_mode                = MODE_READ;
        i_reg_sel             = REG_DATA;
        i_wdata               = '0;
        snd_idle              = 33;
        rcv_idle              = 67;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_protocol(1'b0);

        // Directed: empty pops, data extremes, status codes, ignored and clearing control codes.
        send_word(MODE_READ,  REG_DATA, 8'h3C);
        send_word(MODE_READ,  REG_CTRL, 8'hC3);
        send_word(MODE_WRITE, REG_DATA, 8'h00);
        send_word(MODE_WRITE, REG_DATA, 8'hFF);
        send_word(MODE_WRITE, REG_DATA, 8'hA5);
        send_word(MODE_WRITE, REG_DATA, 8'h5A);
        send_word(MODE_READ,  REG_CTRL, 8'h00);
        send_word(MODE_READ,  REG_DATA, 8'hFF);
        send_word(MODE_READ,  REG_DATA, 8'h00);
        send_word(MODE_WRITE, REG_CTRL, 8'h02);
        send_word(MODE_WRITE, REG_CTRL, 8'hFF);
        send_word(MODE_READ,  REG_CTRL, 8'h55);
        send_word(MODE_WRITE, REG_CTRL, CTRL_CLEAR_A);
        send_word(MODE_READ,  REG_DATA, 8'hAA);
        send_word(MODE_READ,  REG_CTRL, 8'h0F);
        send_word(MODE_WRITE, REG_DATA, 8'h81);
        send_word(MODE_WRITE, REG_CTRL, CTRL_CLEAR_B);
        send_word(MODE_WRITE, REG_DATA, 8'h7E);
        send_word(MODE_WRITE, REG_CTRL, CTRL_CLEAR_C);
        send_word(MODE_READ,  REG_DATA, 8'hF0);

        settle();
        write_protocol(1'b1);
        hold_asked++;
        fill_and_drain();
        run_random(RANDOM_PER_PHASE);

        settle();
        snd_idle = 67;
        rcv_idle = 33;
        write_protocol(1'b0);
        run_random(RANDOM_PER_PHASE);

        settle();
        snd_idle = 0;
        rcv_idle = 0;
        write_protocol(1'b1);
        fill_and_drain();
        run_random(RANDOM_PER_PHASE);

        settle();
        repeat (4) @(negedge i_clk);
        $display("Summary: %0d bus accesses sent, %0d replies checked, both status settings,",
                 words_in, words_out);
        $display("Summary: three pacing phases, %0d pushes dropped at full, %0d pops from empty.",
                 drops, empty_pops);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
